/* rtl/core/pta_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pta_pkg
// shared widths, payload types and the arctangent table of the aim-angle pipe
// ----------------------------------------------------------------------------
package pta_pkg;

   localparam int COORD_WIDTH        = 16;
   localparam int ANGLE_WIDTH        = 16;
   localparam int ANGLE_FRAC_DEFAULT = 8;
   localparam int TABLE_FRAC         = 24;
   localparam int CORDIC_STEPS       = 28;
   localparam int NORM_EXP           = 40;
   localparam int OP_WIDTH           = NORM_EXP + 4;
   localparam int SQ_WIDTH           = 64;
   localparam int ROOT_WIDTH         = SQ_WIDTH / 2;
   localparam int REM_WIDTH          = ROOT_WIDTH + 4;
   localparam int COORD_SCALE        = ROOT_WIDTH - COORD_WIDTH;
   localparam int ACC_WIDTH          = 32;
   localparam int NORM_MAX_SHIFT     = 32;
   localparam int NORM_STEPS         = 6;
   localparam int NORM_STAGES        = 3;
   localparam int RIGHT_ANGLE        = 90;
   localparam int LANES              = 2;
   localparam int LANE_PITCH         = 0;
   localparam int LANE_YAW           = 1;

   typedef struct packed {
      logic signed [COORD_WIDTH-1:0] pos_x;
      logic signed [COORD_WIDTH-1:0] pos_y;
      logic signed [COORD_WIDTH-1:0] pos_z;
   } req_type;

   typedef struct packed {
      logic signed [ANGLE_WIDTH-1:0] pitch_angle;
      logic signed [ANGLE_WIDTH-1:0] yaw_angle;
      logic                          invalid;
   } rsp_type;

   typedef struct packed {
      logic signed [OP_WIDTH-1:0] pitch_num;
      logic signed [OP_WIDTH-1:0] yaw_num;
      logic signed [OP_WIDTH-1:0] yaw_den;
   } side_type;

   typedef struct packed {
      logic [SQ_WIDTH-1:0] sq;
      side_type            side;
   } root_in_type;

   typedef struct packed {
      logic [ROOT_WIDTH-1:0] root;
      side_type              side;
   } root_out_type;

   typedef struct packed {
      logic num_zero;
      logic den_zero;
      logic num_neg;
   } flag_type;

   typedef struct packed {
      logic signed [OP_WIDTH-1:0] num;
      logic signed [OP_WIDTH-1:0] den;
      flag_type                   flags;
   } op_type;

   typedef struct packed {
      logic signed [ACC_WIDTH-1:0] angle;
      flag_type                    flags;
   } angle_type;

   typedef op_type    [LANES-1:0] op_pair_type;
   typedef angle_type [LANES-1:0] angle_pair_type;

   // atan(2^-i) in degrees, 24 fraction bits
   function automatic logic signed [ACC_WIDTH-1:0] atan_entry(input int step);
      logic signed [ACC_WIDTH-1:0] v;
      case (step)
         0:  v = 32'sd754974720;
         1:  v = 32'sd445687602;
         2:  v = 32'sd235489088;
         3:  v = 32'sd119537938;
         4:  v = 32'sd60000934;
         5:  v = 32'sd30029717;
         6:  v = 32'sd15018523;
         7:  v = 32'sd7509720;
         8:  v = 32'sd3754917;
         9:  v = 32'sd1877466;
         10: v = 32'sd938734;
         11: v = 32'sd469367;
         12: v = 32'sd234684;
         13: v = 32'sd117342;
         14: v = 32'sd58671;
         15: v = 32'sd29335;
         16: v = 32'sd14668;
         17: v = 32'sd7334;
         18: v = 32'sd3667;
         19: v = 32'sd1833;
         20: v = 32'sd917;
         21: v = 32'sd458;
         22: v = 32'sd229;
         23: v = 32'sd115;
         24: v = 32'sd57;
         25: v = 32'sd29;
         26: v = 32'sd14;
         27: v = 32'sd7;
         default: v = '0;
      endcase
      return v;
   endfunction

   function automatic int norm_shift(input int step);
      return NORM_MAX_SHIFT >> step;
   endfunction

endpackage

/* rtl/core/position_to_aim_angles.sv */
`timescale 1ns / 1ps
// path: a req transfer passes the input register, the square stage, 32 square-root stages,
//    4 normalisation stages, 28 cordic stages and the output register on its way to rsp
// throughput: one position per cycle unless rsp_stall holds the pipe; the 32-stage square root
//    and 28-stage cordic each retire one item per clock while enabled
// reset: synchronous, clears all valid bits; payload registers are not reset
// ----------------------------------------------------------------------------
// position_to_aim_angles
// camera-frame target position to pitch and yaw aim angles in fixed-point degrees
// ----------------------------------------------------------------------------
module position_to_aim_angles
   import pta_pkg::*;
#(
   parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_DEFAULT
)(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   // rounding and clamping constants for the output field
   localparam int RND_SHIFT   = TABLE_FRAC - ANGLE_FRAC_BITS;
   localparam int ANGLE_LIMIT = RIGHT_ANGLE << ANGLE_FRAC_BITS;
   localparam int FIELD_MAX   = (1 << (ANGLE_WIDTH - 1)) - 1;
   localparam int FIELD_MIN   = -(1 << (ANGLE_WIDTH - 1));
   localparam int CLAMP_HI    = (ANGLE_LIMIT < FIELD_MAX) ? ANGLE_LIMIT : FIELD_MAX;
   localparam int CLAMP_LO    = (-ANGLE_LIMIT > FIELD_MIN) ? -ANGLE_LIMIT : FIELD_MIN;

   // whole pipe advances together; the output register holds a stalled transfer
   logic           enable;
   logic           out_load;

   logic           in_valid_ff;
   req_type        in_data_ff;

   logic           sq_valid;
   root_in_type    sq_data;
   logic           root_valid;
   root_out_type   root_data;
   op_pair_type    norm_in;
   logic           norm_valid;
   op_pair_type    norm_data;
   logic           cordic_valid;
   angle_pair_type cordic_data;

   rsp_type        rsp_data_in;
   rsp_type        rsp_data_ff;
   logic           rsp_valid_ff;

   // the pipe may move while the output waits, as long as its last stage is empty
   assign out_load  = !rsp_valid_ff || !rsp_stall;
   assign enable    = out_load || !cordic_valid;
   assign req_stall = !enable;

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (enable) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         in_data_ff <= req_data;
      end
   end

   pta_square u_square (
      .clock     (clock),
      .reset     (reset),
      .enable    (enable),
      .in_valid  (in_valid_ff),
      .in_data   (in_data_ff),
      .out_valid (sq_valid),
      .out_data  (sq_data)
   );

   pta_sqrt u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .enable    (enable),
      .in_valid  (sq_valid),
      .in_data   (sq_data),
      .out_valid (root_valid),
      .out_data  (root_data)
   );

   // pitch: scaled y over the horizontal range, yaw: mirrored x over |z|
   always_comb begin
      norm_in = '0;
      norm_in[LANE_PITCH].num = root_data.side.pitch_num;
      norm_in[LANE_PITCH].den = OP_WIDTH'(root_data.root);
      norm_in[LANE_YAW].num   = root_data.side.yaw_num;
      norm_in[LANE_YAW].den   = root_data.side.yaw_den;
   end

   pta_norm u_norm (
      .clock     (clock),
      .reset     (reset),
      .enable    (enable),
      .in_valid  (root_valid),
      .in_data   (norm_in),
      .out_valid (norm_valid),
      .out_data  (norm_data)
   );

   pta_cordic u_cordic (
      .clock     (clock),
      .reset     (reset),
      .enable    (enable),
      .in_valid  (norm_valid),
      .in_data   (norm_data),
      .out_valid (cordic_valid),
      .out_data  (cordic_data)
   );

   // special cases, round half up to the field's fraction, clamp and saturate
   function automatic logic signed [ANGLE_WIDTH-1:0] to_field(
      input logic signed [ACC_WIDTH-1:0] a
   );
      logic signed [ACC_WIDTH:0] sum;
      logic signed [ACC_WIDTH:0] v;
      sum = (ACC_WIDTH+1)'(a) + (ACC_WIDTH+1)'(1 << (RND_SHIFT - 1));
      v   = sum >>> RND_SHIFT;
      if (v > (ACC_WIDTH+1)'(CLAMP_HI)) begin
         v = (ACC_WIDTH+1)'(CLAMP_HI);
      end else if (v < (ACC_WIDTH+1)'(CLAMP_LO)) begin
         v = (ACC_WIDTH+1)'(CLAMP_LO);
      end
      return v[ANGLE_WIDTH-1:0];
   endfunction

   always_comb begin
      logic signed [ACC_WIDTH-1:0] ang [LANES];
      logic                        bad;
      bad = 1'b0;
      for (int l = 0; l < LANES; l++) begin
         if (cordic_data[l].flags.num_zero) begin
            ang[l] = '0;
            // zero over zero
            bad = bad | cordic_data[l].flags.den_zero;
         end else if (cordic_data[l].flags.den_zero) begin
            ang[l] = cordic_data[l].flags.num_neg ? -(ACC_WIDTH'(RIGHT_ANGLE) << TABLE_FRAC)
                                                  :  (ACC_WIDTH'(RIGHT_ANGLE) << TABLE_FRAC);
         end else begin
            ang[l] = cordic_data[l].angle;
         end
      end
      // pitch is the negated elevation (y points down)
      rsp_data_in.pitch_angle = to_field(-ang[LANE_PITCH]);
      rsp_data_in.yaw_angle   = to_field(ang[LANE_YAW]);
      rsp_data_in.invalid     = bad;
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= cordic_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // a waiting result with a full last stage must hold the input side
   a_hold_input: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall && cordic_valid |-> req_stall)
      else $error("input taken while the pipe is blocked");

   // an invalid flag always comes with a zeroed angle
   a_invalid_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.invalid |-> rsp_data.pitch_angle == '0 || rsp_data.yaw_angle == '0)
      else $error("invalid flag without a zero angle");

   // a transfer taken at the input enters the pipe
   a_accept_enters: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> in_valid_ff)
      else $error("accepted position lost at the input register");

endmodule

/* rtl/core/pta_square.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pta_square
// squares of x and z, scaled sum for the root, and the atan operands
// ----------------------------------------------------------------------------
module pta_square
   import pta_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        enable,
   input  logic        in_valid,
   input  req_type     in_data,
   output logic        out_valid,
   output root_in_type out_data
);

   logic signed [2*COORD_WIDTH-1:0] x_sq;
   logic signed [2*COORD_WIDTH-1:0] z_sq;
   logic        [2*COORD_WIDTH-1:0] sq_sum;
   logic signed [OP_WIDTH-1:0]      x_ext;
   logic signed [OP_WIDTH-1:0]      z_ext;
   root_in_type                     data_in;
   logic                            valid_ff;
   root_in_type                     data_ff;

   always_comb begin
      x_sq    = in_data.pos_x * in_data.pos_x;
      z_sq    = in_data.pos_z * in_data.pos_z;
      sq_sum  = $unsigned(x_sq) + $unsigned(z_sq);
      x_ext   = OP_WIDTH'(in_data.pos_x);
      z_ext   = OP_WIDTH'(in_data.pos_z);
      data_in.sq             = SQ_WIDTH'(sq_sum) << (2 * COORD_SCALE);
      data_in.side.pitch_num = OP_WIDTH'(in_data.pos_y) <<< COORD_SCALE;
      // z behind the camera: mirror both so the denominator is non-negative
      data_in.side.yaw_num   = in_data.pos_z[COORD_WIDTH-1] ? -x_ext : x_ext;
      data_in.side.yaw_den   = in_data.pos_z[COORD_WIDTH-1] ? -z_ext : z_ext;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (enable) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

/* rtl/core/pta_sqrt.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pta_sqrt
// pipelined digit-by-digit integer square root, one root bit per stage
// ----------------------------------------------------------------------------
module pta_sqrt
   import pta_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         enable,
   input  logic         in_valid,
   input  root_in_type  in_data,
   output logic         out_valid,
   output root_out_type out_data
);

   logic [REM_WIDTH-1:0]  rem_w   [0:ROOT_WIDTH];
   logic [ROOT_WIDTH-1:0] root_w  [0:ROOT_WIDTH];
   logic [SQ_WIDTH-1:0]   val_w   [0:ROOT_WIDTH];
   side_type              side_w  [0:ROOT_WIDTH];
   logic                  valid_w [0:ROOT_WIDTH];

   assign rem_w[0]   = '0;
   assign root_w[0]  = '0;
   assign val_w[0]   = in_data.sq;
   assign side_w[0]  = in_data.side;
   assign valid_w[0] = in_valid;

   for (genvar k = 0; k < ROOT_WIDTH; k++) begin : g_stage
      logic [REM_WIDTH-1:0]  rem_sh;
      logic [REM_WIDTH-1:0]  trial;
      logic [REM_WIDTH-1:0]  rem_in;
      logic [ROOT_WIDTH-1:0] root_in;
      logic [REM_WIDTH-1:0]  rem_ff;
      logic [ROOT_WIDTH-1:0] root_ff;
      logic [SQ_WIDTH-1:0]   val_ff;
      side_type              side_ff;
      logic                  valid_ff;

      always_comb begin
         rem_sh = {rem_w[k][REM_WIDTH-3:0], val_w[k][SQ_WIDTH-1 -: 2]};
         trial  = REM_WIDTH'({root_w[k], 2'b01});
         if (rem_sh >= trial) begin
            rem_in  = rem_sh - trial;
            root_in = {root_w[k][ROOT_WIDTH-2:0], 1'b1};
         end else begin
            rem_in  = rem_sh;
            root_in = {root_w[k][ROOT_WIDTH-2:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff <= 1'b0;
         end else if (enable) begin
            valid_ff <= valid_w[k];
         end
      end

      always_ff @(posedge clock) begin
         if (enable) begin
            rem_ff  <= rem_in;
            root_ff <= root_in;
            val_ff  <= val_w[k] << 2;
            side_ff <= side_w[k];
         end
      end

      assign rem_w[k+1]   = rem_ff;
      assign root_w[k+1]  = root_ff;
      assign val_w[k+1]   = val_ff;
      assign side_w[k+1]  = side_ff;
      assign valid_w[k+1] = valid_ff;
   end

   assign out_valid     = valid_w[ROOT_WIDTH];
   assign out_data.root = root_w[ROOT_WIDTH];
   assign out_data.side = side_w[ROOT_WIDTH];

   // remainder of a floor root never exceeds twice the root
   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      out_valid |-> rem_w[ROOT_WIDTH] <= REM_WIDTH'({root_w[ROOT_WIDTH], 1'b0}))
      else $error("square root remainder out of range");

endmodule

/* rtl/core/pta_norm.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pta_norm
// zero detection and left normalisation of both atan operand pairs
// ----------------------------------------------------------------------------
module pta_norm
   import pta_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        enable,
   input  logic        in_valid,
   input  op_pair_type in_data,
   output logic        out_valid,
   output op_pair_type out_data
);

   localparam int STEPS_PER_STAGE = NORM_STEPS / NORM_STAGES;

   typedef logic [LANES-1:0][OP_WIDTH-1:0] mag_pair_type;

   op_pair_type  ops_w   [0:NORM_STAGES];
   mag_pair_type mag_w   [0:NORM_STAGES];
   logic         valid_w [0:NORM_STAGES];

   // first stage: flags and larger magnitude
   op_pair_type  pre_in;
   mag_pair_type pre_mag_in;
   op_pair_type  pre_ff;
   mag_pair_type pre_mag_ff;
   logic         pre_valid_ff;

   always_comb begin
      for (int l = 0; l < LANES; l++) begin
         logic [OP_WIDTH-1:0] num_abs;
         num_abs = in_data[l].num[OP_WIDTH-1] ? $unsigned(-in_data[l].num)
                                              : $unsigned(in_data[l].num);
         pre_in[l].num            = in_data[l].num;
         pre_in[l].den            = in_data[l].den;
         pre_in[l].flags.num_zero = (in_data[l].num == '0);
         pre_in[l].flags.den_zero = (in_data[l].den == '0);
         pre_in[l].flags.num_neg  = in_data[l].num[OP_WIDTH-1];
         pre_mag_in[l] = (num_abs > $unsigned(in_data[l].den)) ? num_abs
                                                                : $unsigned(in_data[l].den);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pre_valid_ff <= 1'b0;
      end else if (enable) begin
         pre_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         pre_ff     <= pre_in;
         pre_mag_ff <= pre_mag_in;
      end
   end

   assign ops_w[0]   = pre_ff;
   assign mag_w[0]   = pre_mag_ff;
   assign valid_w[0] = pre_valid_ff;

   for (genvar st = 0; st < NORM_STAGES; st++) begin : g_stage
      op_pair_type  ops_in;
      mag_pair_type mag_in;
      op_pair_type  ops_ff;
      mag_pair_type mag_ff;
      logic         valid_ff;

      always_comb begin
         ops_in = ops_w[st];
         mag_in = mag_w[st];
         for (int l = 0; l < LANES; l++) begin
            for (int h = 0; h < STEPS_PER_STAGE; h++) begin
               if (mag_in[l] < (OP_WIDTH'(1) << (NORM_EXP + 1
                                 - norm_shift(st * STEPS_PER_STAGE + h)))) begin
                  mag_in[l]     = mag_in[l] << norm_shift(st * STEPS_PER_STAGE + h);
                  ops_in[l].num = ops_in[l].num <<< norm_shift(st * STEPS_PER_STAGE + h);
                  ops_in[l].den = ops_in[l].den <<< norm_shift(st * STEPS_PER_STAGE + h);
               end
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff <= 1'b0;
         end else if (enable) begin
            valid_ff <= valid_w[st];
         end
      end

      always_ff @(posedge clock) begin
         if (enable) begin
            ops_ff <= ops_in;
            mag_ff <= mag_in;
         end
      end

      assign ops_w[st+1]   = ops_ff;
      assign mag_w[st+1]   = mag_ff;
      assign valid_w[st+1] = valid_ff;
   end

   assign out_valid = valid_w[NORM_STAGES];
   assign out_data  = ops_w[NORM_STAGES];

   // a yaw operand pair that is not all zero leaves with its larger magnitude in [2^40, 2^41)
   a_norm_range: assert property (@(posedge clock) disable iff (reset)
      out_valid && !(out_data[LANE_YAW].flags.num_zero && out_data[LANE_YAW].flags.den_zero)
      |-> mag_w[NORM_STAGES][LANE_YAW] >= (OP_WIDTH'(1) << NORM_EXP)
          && mag_w[NORM_STAGES][LANE_YAW] < (OP_WIDTH'(1) << (NORM_EXP + 1)))
      else $error("yaw operands not normalised");

endmodule

/* rtl/core/pta_cordic.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pta_cordic
// vectoring cordic, one micro-rotation per stage, two lanes side by side
// ----------------------------------------------------------------------------
module pta_cordic
   import pta_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           enable,
   input  logic           in_valid,
   input  op_pair_type    in_data,
   output logic           out_valid,
   output angle_pair_type out_data
);

   typedef logic signed [LANES-1:0][OP_WIDTH-1:0]  vec_pair_type;
   typedef logic signed [LANES-1:0][ACC_WIDTH-1:0] acc_pair_type;
   typedef flag_type    [LANES-1:0]                flag_pair_type;

   vec_pair_type  x_w     [0:CORDIC_STEPS];
   vec_pair_type  y_w     [0:CORDIC_STEPS];
   acc_pair_type  z_w     [0:CORDIC_STEPS];
   flag_pair_type flags_w [0:CORDIC_STEPS];
   logic          valid_w [0:CORDIC_STEPS];

   for (genvar l = 0; l < LANES; l++) begin : g_entry
      assign x_w[0][l]     = in_data[l].den;
      assign y_w[0][l]     = in_data[l].num;
      assign z_w[0][l]     = '0;
      assign flags_w[0][l] = in_data[l].flags;
   end
   assign valid_w[0] = in_valid;

   for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_stage
      vec_pair_type  x_in;
      vec_pair_type  y_in;
      acc_pair_type  z_in;
      vec_pair_type  x_ff;
      vec_pair_type  y_ff;
      acc_pair_type  z_ff;
      flag_pair_type flags_ff;
      logic          valid_ff;

      always_comb begin
         for (int l = 0; l < LANES; l++) begin
            logic signed [OP_WIDTH-1:0] xs;
            logic signed [OP_WIDTH-1:0] ys;
            // a lane select of a packed pair is unsigned, so re-sign it
            xs = $signed(x_w[i][l]) >>> i;
            ys = $signed(y_w[i][l]) >>> i;
            if ($signed(y_w[i][l]) > 0) begin
               x_in[l] = x_w[i][l] + ys;
               y_in[l] = y_w[i][l] - xs;
               z_in[l] = z_w[i][l] + atan_entry(i);
            end else begin
               x_in[l] = x_w[i][l] - ys;
               y_in[l] = y_w[i][l] + xs;
               z_in[l] = z_w[i][l] - atan_entry(i);
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff <= 1'b0;
         end else if (enable) begin
            valid_ff <= valid_w[i];
         end
      end

      always_ff @(posedge clock) begin
         if (enable) begin
            x_ff     <= x_in;
            y_ff     <= y_in;
            z_ff     <= z_in;
            flags_ff <= flags_w[i];
         end
      end

      assign x_w[i+1]     = x_ff;
      assign y_w[i+1]     = y_ff;
      assign z_w[i+1]     = z_ff;
      assign flags_w[i+1] = flags_ff;
      assign valid_w[i+1] = valid_ff;
   end

   for (genvar l = 0; l < LANES; l++) begin : g_exit
      assign out_data[l].angle = z_w[CORDIC_STEPS][l];
      assign out_data[l].flags = flags_w[CORDIC_STEPS][l];
   end
   assign out_valid = valid_w[CORDIC_STEPS];

endmodule

/* dv/position_to_aim_angles_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// position_to_aim_angles_checker
// watches both channels, predicts aim angles per position transfer and
// compares each result transfer against the oldest prediction
// ----------------------------------------------------------------------------
module position_to_aim_angles_checker
   import pta_pkg::*;
#(
   parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_DEFAULT
)(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  logic    req_stall,
   input  req_type req_data,
   input  logic    rsp_valid,
   input  logic    rsp_stall,
   input  rsp_type rsp_data,
   output int      fail_count,
   output int      pending_count
);

   rsp_type angles_due[$];

   function automatic longint floor_shr(longint v, int s);
      return v >>> s;
   endfunction

   function automatic longint int_sqrt(longint unsigned v);
      longint unsigned res, bit_pos;
      res = 0;
      bit_pos = 64'd1 << 62;
      while (bit_pos > v) bit_pos = bit_pos >> 2;
      while (bit_pos != 0) begin
         if (v >= res + bit_pos) begin
            v = v - (res + bit_pos);
            res = (res >> 1) + bit_pos;
         end else begin
            res = res >> 1;
         end
         bit_pos = bit_pos >> 2;
      end
      return longint'(res);
   endfunction

   // degrees * 2^24 for num/den with den >= 0, zero over zero flagged
   function automatic longint atan_deg(longint num, longint den, ref bit zero_zero);
      longint cx, cy, acc, mag, xs, ys;
      if (num == 0) begin
         if (den == 0) zero_zero = 1'b1;
         return 0;
      end
      if (den == 0) return (num > 0) ? (64'sd90 <<< 24) : -(64'sd90 <<< 24);
      cx = den; cy = num; acc = 0;
      mag = (cy < 0) ? -cy : cy;
      if (cx > mag) mag = cx;
      while (mag < (64'sd1 <<< 40)) begin
         cx = cx * 2; cy = cy * 2; mag = mag * 2;
      end
      for (int i = 0; i < CORDIC_STEPS; i++) begin
         xs = floor_shr(cx, i);
         ys = floor_shr(cy, i);
         if (cy > 0) begin
            cx += ys; cy -= xs; acc += longint'(atan_entry(i));
         end else begin
            cx -= ys; cy += xs; acc -= longint'(atan_entry(i));
         end
      end
      return acc;
   endfunction

   function automatic logic [ANGLE_WIDTH-1:0] round_angle(longint a);
      longint v, lim;
      int s;
      s = TABLE_FRAC - ANGLE_FRAC_BITS;
      lim = 64'sd90 <<< ANGLE_FRAC_BITS;
      v = floor_shr(a + (64'sd1 <<< (s - 1)), s);
      if (v > lim) v = lim;
      if (v < -lim) v = -lim;
      if (v > 32767) v = 32767;
      if (v < -32768) v = -32768;
      return v[ANGLE_WIDTH-1:0];
   endfunction

   function automatic rsp_type aim_angles(req_type p);
      rsp_type r;
      longint x, y, z, root;
      longint unsigned sq;
      bit zero_zero;
      int sc;
      zero_zero = 1'b0;
      sc = 32 - COORD_WIDTH;
      x = p.pos_x; y = p.pos_y; z = p.pos_z;
      sq = longint'(x * x + z * z) << (2 * sc);
      root = int_sqrt(sq);
      r.pitch_angle = round_angle(-atan_deg(y * (64'sd1 <<< sc), root, zero_zero));
      r.yaw_angle = round_angle(atan_deg((z < 0) ? -x : x, (z < 0) ? -z : z, zero_zero));
      r.invalid = zero_zero;
      return r;
   endfunction

   assign pending_count = angles_due.size();

   always @(posedge clock) begin
      rsp_type got, want;
      if (!reset && req_valid && !req_stall)
         angles_due = {angles_due, aim_angles(req_data)};
      if (!reset && rsp_valid && !rsp_stall) begin
         got = rsp_data;
         if (angles_due.size() == 0) begin
            $error("result transfer with nothing expected: %p", got);
            fail_count++;
         end else begin
            want = angles_due.pop_front();
            if (got.pitch_angle !== want.pitch_angle) begin
               $error("pitch_angle expected %0d actual %0d", want.pitch_angle,
                      got.pitch_angle);
               fail_count++;
            end
            if (got.yaw_angle !== want.yaw_angle) begin
               $error("yaw_angle expected %0d actual %0d", want.yaw_angle, got.yaw_angle);
               fail_count++;
            end
            if (got.invalid !== want.invalid) begin
               $error("invalid expected %0b actual %0b", want.invalid, got.invalid);
               fail_count++;
            end
         end
      end
   end

endmodule

/* dv/position_to_aim_angles_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// position_to_aim_angles_tb
// drives directed and random target positions through the aim-angle pipe with
// bursty transfers and receiver stalls; the checker does the comparing
// ----------------------------------------------------------------------------
module position_to_aim_angles_tb;
   import pta_pkg::*;

   localparam int RANDOM_ITEMS = 1100;
   localparam int DRAIN_CYCLES = 100;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_stall;
   rsp_type rsp_data;
   int      fail_count;
   int      pending_count;

   position_to_aim_angles u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
   );

   position_to_aim_angles_checker u_checker (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .fail_count(fail_count), .pending_count(pending_count)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // generous limit well beyond the slowest stalled run
   initial begin
      #20ms;
      $display("Test completed with failures");
      $finish;
   end

   // receiver stall pattern: phases of no stall, light and heavy stall
   initial begin
      int phase_left, stall_pct;
      rsp_stall = 1'b0;
      phase_left = 0;
      stall_pct = 0;
      forever begin
         @(negedge clock);
         if (phase_left == 0) begin
            phase_left = $urandom_range(200, 20);
            case ($urandom_range(2, 0))
               0: stall_pct = 0;
               1: stall_pct = 25;
               default: stall_pct = 80;
            endcase
         end
         phase_left--;
         rsp_stall <= ($urandom_range(99, 0) < stall_pct);
      end
   end

   // one position transfer, valid held until accepted
   task automatic send_position(input logic [15:0] x, input logic [15:0] y,
                                input logic [15:0] z);
      req_data.pos_x <= x;
      req_data.pos_y <= y;
      req_data.pos_z <= z;
      req_valid <= 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic idle_gap(input int cycles);
      req_valid <= 1'b0;
      repeat (cycles) @(negedge clock);
   endtask

   // coordinate with bias towards zero, extremes and small magnitudes
   function automatic logic [15:0] pick_coord();
      case ($urandom_range(9, 0))
         0: return 16'h0000;
         1: return 16'h7fff;
         2: return 16'h8000;
         3: return 16'($signed($urandom_range(8, 0)) - 4);
         4: return 16'($signed($urandom_range(400, 0)) - 200);
         default: return 16'($urandom);
      endcase
   endfunction

   initial begin
      int burst, drain;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: zero over zero, right angles, extremes, axis cases
      send_position(16'd0, 16'd0, 16'd0);
      send_position(16'd0, 16'd5, 16'd0);
      send_position(16'd0, -16'sd5, 16'd0);
      send_position(16'd7, 16'd0, 16'd0);
      send_position(-16'sd7, 16'd3, 16'd0);
      send_position(16'd0, 16'd0, 16'd100);
      send_position(16'd0, 16'd0, -16'sd100);
      send_position(16'd100, 16'd100, 16'd100);
      send_position(-16'sd100, -16'sd100, -16'sd100);
      send_position(16'd100, 16'd0, -16'sd100);
      send_position(16'h7fff, 16'h7fff, 16'h7fff);
      send_position(16'h8000, 16'h8000, 16'h8000);
      send_position(16'h7fff, 16'h8000, 16'h0001);
      send_position(16'h8000, 16'h7fff, 16'hffff);
      send_position(16'h0001, 16'h7fff, 16'h0000);
      send_position(16'hffff, 16'h8000, 16'h0001);
      send_position(16'h0001, 16'h0001, 16'h7fff);
      send_position(16'h5555, 16'haaaa, 16'h5555);
      send_position(16'haaaa, 16'h5555, 16'haaaa);
      idle_gap(3);

      // random bursts with gaps between them
      burst = 0;
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (burst == 0) begin
            burst = $urandom_range(40, 1);
            if ($urandom_range(3, 0) != 0) idle_gap($urandom_range(12, 1));
         end
         burst--;
         send_position(pick_coord(), pick_coord(), pick_coord());
      end
      req_valid <= 1'b0;

      // drain: wait for outstanding results, then the pipe latency
      drain = 0;
      while (pending_count != 0 && drain < 200000) begin
         @(posedge clock);
         drain++;
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0 && pending_count == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule

/* filelist.f */
rtl/core/pta_pkg.sv
rtl/core/pta_square.sv
rtl/core/pta_sqrt.sv
rtl/core/pta_norm.sv
rtl/core/pta_cordic.sv
rtl/core/position_to_aim_angles.sv
dv/position_to_aim_angles_checker.sv
dv/position_to_aim_angles_tb.sv
